FILE: src/sukset_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sukset_pkg;

	localparam int CAPACITY  = 32;
	localparam int KEY_W     = 32;
	localparam int COUNT_W   = $clog2(CAPACITY + 1);
	localparam int CURSOR_W  = $clog2(CAPACITY);
	localparam int CMD_W     = 2;
	localparam int STATUS_W  = 3;
	localparam int IN_DATA_W  = ((CMD_W + KEY_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((STATUS_W + KEY_W + 7) / 8) * 8;

	// command codes
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_DUP     = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_MISSING = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_EMPTY   = 3'd4;

	// operations broadcast along the cell row
	localparam logic [1:0] OP_HOLD   = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;
	localparam logic [1:0] OP_ROTATE = 2'd3;

	typedef struct packed {
		logic [1:0]       op;
		logic [KEY_W-1:0] ins_key;
		logic             cmp_en;
		logic [KEY_W-1:0] cmp_key;
	} cell_ctrl_t;

endpackage
`default_nettype wire

FILE: src/sukset_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module sukset_cell (
	input  wire                         clk,
	input  wire                         arst_n,
	input  sukset_pkg::cell_ctrl_t      ctrl,
	input  wire                         left_lt,
	input  wire [sukset_pkg::KEY_W-1:0] left_key,
	input  wire                         left_valid,
	input  wire [sukset_pkg::KEY_W-1:0] right_key,
	input  wire                         right_valid,
	input  wire [sukset_pkg::KEY_W-1:0] head_key,
	output logic [sukset_pkg::KEY_W-1:0] key_q,
	output logic                        valid_q,
	output logic                        lt_q,
	output logic                        eq_q
);

	// compare result of the pending request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctrl.cmp_en) begin
			lt_q <= valid_q && ($signed(key_q) < $signed(ctrl.cmp_key));
			eq_q <= valid_q && (key_q == ctrl.cmp_key);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctrl.op)
				sukset_pkg::OP_INSERT: begin
					if (!lt_q) begin
						valid_q <= left_lt ? 1'b1 : left_valid;
					end
				end
				sukset_pkg::OP_DELETE: begin
					if (!lt_q) begin
						valid_q <= right_valid;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// key storage carries no reset
	always_ff @(posedge clk) begin
		case (ctrl.op)
			sukset_pkg::OP_INSERT: begin
				if (!lt_q) begin
					key_q <= left_lt ? ctrl.ins_key : left_key;
				end
			end
			sukset_pkg::OP_DELETE: begin
				if (!lt_q) begin
					key_q <= right_key;
				end
			end
			sukset_pkg::OP_ROTATE: begin
				if (valid_q) begin
					key_q <= right_valid ? right_key : head_key;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: src/sorted_unique_key_set_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// sorted set of up to 32 distinct signed 32-bit keys, kept in ascending order in a row of
// shift cells (cell 0 holds the smallest key). an insert or delete transaction is compared
// against every cell in the cycle it is accepted; the compare result is registered in the
// cells, and the shift is applied in the exec state once the result register is free.
// a dump returns the stored keys from cell 0 while the row rotates one place per cycle
// whenever the result register is free; a dump of an empty set gives a single result
// with status empty. the row is back in order when the dump ends.
// one transaction is worked on at a time; the next can be accepted while the last result
// still waits in the output register. unused command codes are accepted and dropped.
module sorted_unique_key_set_unit (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// command [1:0], key [33:2], zero fill above
	input  wire [sukset_pkg::IN_DATA_W-1:0]   s_tdata,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// status [2:0], value [34:3], zero fill above
	output logic [sukset_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                              m_tlast
);

	localparam int CAP  = sukset_pkg::CAPACITY;
	localparam int KW   = sukset_pkg::KEY_W;
	localparam int CNTW = sukset_pkg::COUNT_W;
	localparam int CURW = sukset_pkg::CURSOR_W;

	// control states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_DUMP = 2'd2;

	logic [1:0] state_q;
	logic [sukset_pkg::CMD_W-1:0] cmd_q;
	logic [KW-1:0] key_q;
	logic [CNTW-1:0] count_q;
	logic [CURW-1:0] cursor_q;

	// output register
	logic m_valid_q;
	logic [sukset_pkg::STATUS_W-1:0] status_q;
	logic [KW-1:0] value_q;
	logic last_q;

	logic [sukset_pkg::CMD_W-1:0] in_cmd;
	logic [KW-1:0] in_key;
	logic in_accept;
	logic out_free;

	// cell row
	logic [KW-1:0] cell_key [CAP];
	logic [CAP-1:0] cell_valid;
	logic [CAP-1:0] cell_lt;
	logic [CAP-1:0] cell_eq;
	sukset_pkg::cell_ctrl_t ctrl;

	logic found;
	logic full;
	logic dump_last;

	// emit request for the output register
	logic emit;
	logic [sukset_pkg::STATUS_W-1:0] emit_status;
	logic [KW-1:0] emit_value;
	logic emit_last;

	assign in_cmd    = s_tdata[sukset_pkg::CMD_W-1:0];
	assign in_key    = s_tdata[sukset_pkg::CMD_W +: KW];
	assign s_tready  = (state_q == ST_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign out_free  = !m_valid_q || m_tready;

	assign found     = |cell_eq;
	assign full      = (count_q == CNTW'(CAP));
	assign dump_last = ((CNTW'(cursor_q) + CNTW'(1)) == count_q);

	genvar i;
	generate
		for (i = 0; i < CAP; i++) begin : g_cell
			logic left_lt;
			logic [KW-1:0] left_key;
			logic left_valid;
			logic [KW-1:0] right_key;
			logic right_valid;

			if (i == 0) begin : g_first
				// nothing to the left: the new key lands here when this cell is not below it
				assign left_lt    = 1'b1;
				assign left_key   = cell_key[0];
				assign left_valid = 1'b0;
			end else begin : g_inner
				assign left_lt    = cell_lt[i-1];
				assign left_key   = cell_key[i-1];
				assign left_valid = cell_valid[i-1];
			end

			if (i == CAP - 1) begin : g_last
				assign right_key   = cell_key[i];
				assign right_valid = 1'b0;
			end else begin : g_body
				assign right_key   = cell_key[i+1];
				assign right_valid = cell_valid[i+1];
			end

			sukset_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (ctrl),
				.left_lt     (left_lt),
				.left_key    (left_key),
				.left_valid  (left_valid),
				.right_key   (right_key),
				.right_valid (right_valid),
				.head_key    (cell_key[0]),
				.key_q       (cell_key[i]),
				.valid_q     (cell_valid[i]),
				.lt_q        (cell_lt[i]),
				.eq_q        (cell_eq[i])
			);
		end
	endgenerate

	// row control and result selection
	always_comb begin
		ctrl.op      = sukset_pkg::OP_HOLD;
		ctrl.ins_key = key_q;
		ctrl.cmp_key = in_key;
		ctrl.cmp_en  = in_accept &&
			((in_cmd == sukset_pkg::CMD_INSERT) || (in_cmd == sukset_pkg::CMD_DELETE));
		emit        = 1'b0;
		emit_status = sukset_pkg::STAT_OK;
		emit_value  = key_q;
		emit_last   = 1'b1;
		case (state_q)
			ST_EXEC: begin
				if (out_free) begin
					emit = 1'b1;
					if (cmd_q == sukset_pkg::CMD_INSERT) begin
						// duplicate check takes priority over full
						if (found) begin
							emit_status = sukset_pkg::STAT_DUP;
						end else if (full) begin
							emit_status = sukset_pkg::STAT_FULL;
						end else begin
							ctrl.op = sukset_pkg::OP_INSERT;
						end
					end else begin
						if (found) begin
							ctrl.op = sukset_pkg::OP_DELETE;
						end else begin
							emit_status = sukset_pkg::STAT_MISSING;
						end
					end
				end
			end
			ST_DUMP: begin
				if (out_free) begin
					emit = 1'b1;
					if (count_q == '0) begin
						emit_status = sukset_pkg::STAT_EMPTY;
						emit_value  = '0;
					end else begin
						// head cell out, whole occupied row moves one place down
						emit_value = cell_key[0];
						emit_last  = dump_last;
						ctrl.op    = sukset_pkg::OP_ROTATE;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			cursor_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						if ((in_cmd == sukset_pkg::CMD_INSERT) ||
							(in_cmd == sukset_pkg::CMD_DELETE)) begin
							state_q <= ST_EXEC;
						end else if (in_cmd == sukset_pkg::CMD_DUMP) begin
							state_q <= ST_DUMP;
						end
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (ctrl.op == sukset_pkg::OP_INSERT) begin
							count_q <= count_q + CNTW'(1);
						end else if (ctrl.op == sukset_pkg::OP_DELETE) begin
							count_q <= count_q - CNTW'(1);
						end
					end
				end
				ST_DUMP: begin
					if (out_free) begin
						if ((count_q == '0) || dump_last) begin
							state_q  <= ST_IDLE;
							cursor_q <= '0;
						end else begin
							cursor_q <= cursor_q + CURW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q <= in_cmd;
			key_q <= in_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q <= emit_status;
			value_q  <= emit_value;
			last_q   <= emit_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {{(sukset_pkg::OUT_DATA_W - sukset_pkg::STATUS_W - KW){1'b0}},
		value_q, status_q};

endmodule
`default_nettype wire

FILE: dv/tb_sorted_unique_key_set_unit.sv
`timescale 1ns / 1ps
// checks the sorted unique key set against a shadow copy of the set kept in the bench.
// every accepted transaction updates the shadow set and queues the results it should give;
// every result transaction is compared field by field with the oldest queued one.
// stimulus: a short directed pass over the edge cases, then random mixes shaped so that
// keys collide often, a fill to capacity and back down to empty, and a stretch with no
// idling on either side.
module tb_sorted_unique_key_set_unit;

	localparam int CAPACITY   = sukset_pkg::CAPACITY;
	localparam int KEY_W      = sukset_pkg::KEY_W;
	localparam int CMD_W      = sukset_pkg::CMD_W;
	localparam int STATUS_W   = sukset_pkg::STATUS_W;
	localparam int IN_DATA_W  = sukset_pkg::IN_DATA_W;
	localparam int OUT_DATA_W = sukset_pkg::OUT_DATA_W;

	localparam int CYCLE_LIMIT = 400000;
	// wait after the last awaited result so that a late or stray result can still show
	localparam int SETTLE_CYCLES = 64;
	// the one command code the block accepts and drops
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [KEY_W-1:0]    value;
		logic                last;
	} set_result_t;

	logic                  clk;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;

	// shadow of the stored set: ascending in entries 0..set_count-1
	logic signed [KEY_W-1:0] set_keys [CAPACITY];
	int                      set_count = 0;
	set_result_t             awaited_results [$];

	int fault_count = 0;
	int cycle_count = 0;
	bit gaps_on     = 1'b1;

	sorted_unique_key_set_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: a hung handshake or a lost result ends here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sorted_unique_key_set_unit verification failed");
			$finish;
		end
	end

	// receiver: drops ready at random, with a chance of 17 in 100, while gaps are switched on
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= !(gaps_on && $urandom_range(99) < 17);
	end

	// applies one accepted transaction to the shadow set and queues what it should return
	function automatic void shadow_set_apply(input logic [CMD_W-1:0] cmd,
			input logic signed [KEY_W-1:0] key);
		int          pos;
		int          i;
		bit          hit;
		set_result_t res;
		pos = 0;
		while (pos < set_count && set_keys[pos] < key)
			pos++;
		hit = (pos < set_count) && (set_keys[pos] == key);
		res.value = key;
		res.last  = 1'b1;
		case (cmd)
			sukset_pkg::CMD_INSERT: begin
				// duplicate check wins over the full check
				if (hit) begin
					res.status = sukset_pkg::STAT_DUP;
				end else if (set_count >= CAPACITY) begin
					res.status = sukset_pkg::STAT_FULL;
				end else begin
					for (i = set_count; i > pos; i--)
						set_keys[i] = set_keys[i-1];
					set_keys[pos] = key;
					set_count++;
					res.status = sukset_pkg::STAT_OK;
				end
				awaited_results.push_back(res);
			end
			sukset_pkg::CMD_DELETE: begin
				if (hit) begin
					for (i = pos; i + 1 < set_count; i++)
						set_keys[i] = set_keys[i+1];
					set_count--;
					res.status = sukset_pkg::STAT_OK;
				end else begin
					res.status = sukset_pkg::STAT_MISSING;
				end
				awaited_results.push_back(res);
			end
			sukset_pkg::CMD_DUMP: begin
				if (set_count == 0) begin
					res.status = sukset_pkg::STAT_EMPTY;
					res.value  = '0;
					awaited_results.push_back(res);
				end else begin
					for (i = 0; i < set_count; i++) begin
						res.status = sukset_pkg::STAT_OK;
						res.value  = set_keys[i];
						res.last   = (i == set_count - 1);
						awaited_results.push_back(res);
					end
				end
			end
			default: begin
				// unused code: dropped without a result
			end
		endcase
	endfunction

	// keys biased towards collisions so that duplicates and successful deletes are common
	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 40 && set_count > 0)
			return set_keys[$urandom_range(set_count - 1)];
		if (r < 65)
			return KEY_W'($urandom_range(16)) - KEY_W'(8);
		if (r < 75) begin
			case ($urandom_range(3))
				0: return {1'b1, {(KEY_W-1){1'b0}}};
				1: return {1'b0, {(KEY_W-1){1'b1}}};
				2: return '0;
				default: return '1;
			endcase
		end
		return $urandom();
	endfunction

	function automatic logic [CMD_W-1:0] pick_command();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return sukset_pkg::CMD_INSERT;
		if (r < 80)
			return sukset_pkg::CMD_DELETE;
		if (r < 95)
			return sukset_pkg::CMD_DUMP;
		return CMD_UNUSED;
	endfunction

	function automatic void flag_fault(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%s", msg);
	endfunction

	// sends one transaction; entered and left just after a rising edge, valid stays high
	// on return so that back-to-back transactions need no second assignment in one step
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key);
		if (gaps_on) begin
			while ($urandom_range(99) < 17) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_DATA_W-KEY_W-CMD_W){1'b0}}, key, cmd};
		do
			@(posedge clk);
		while (!s_tready);
		shadow_set_apply(cmd, key);
	endtask

	// result checker: pre-edge values are sampled in the active region of the edge
	always @(posedge clk) begin
		set_result_t         want;
		logic [STATUS_W-1:0] got_status;
		logic [KEY_W-1:0]    got_value;
		if (arst_n && m_tvalid && m_tready) begin
			got_status = m_tdata[STATUS_W-1:0];
			got_value  = m_tdata[STATUS_W +: KEY_W];
			if (awaited_results.size() == 0) begin
				flag_fault($sformatf("unexpected result: status %0d value %0d last %0b",
					got_status, $signed(got_value), m_tlast));
			end else begin
				want = awaited_results.pop_front();
				if (got_status !== want.status || got_value !== want.value ||
						m_tlast !== want.last)
					flag_fault($sformatf({"result mismatch: expected status %0d value %0d ",
						"last %0b, got status %0d value %0d last %0b"},
						want.status, $signed(want.value), want.last,
						got_status, $signed(got_value), m_tlast));
			end
		end
	end

	// edge cases: empty dump, missing delete, extreme keys, duplicates, unused code
	task automatic test_directed();
		send_item(sukset_pkg::CMD_DUMP, '0);
		send_item(sukset_pkg::CMD_DELETE, 32'd5);
		send_item(sukset_pkg::CMD_INSERT, 32'd0);
		send_item(sukset_pkg::CMD_INSERT, 32'h8000_0000);
		send_item(sukset_pkg::CMD_INSERT, 32'h7fff_ffff);
		send_item(sukset_pkg::CMD_INSERT, 32'hffff_ffff);
		send_item(sukset_pkg::CMD_INSERT, 32'd1);
		send_item(sukset_pkg::CMD_INSERT, 32'd0);
		send_item(sukset_pkg::CMD_INSERT, 32'h8000_0000);
		send_item(CMD_UNUSED, 32'hffff_ffff);
		send_item(sukset_pkg::CMD_DUMP, 32'hffff_ffff);
		send_item(sukset_pkg::CMD_DELETE, 32'h7fff_ffff);
		send_item(sukset_pkg::CMD_DELETE, 32'd0);
		send_item(sukset_pkg::CMD_DELETE, 32'd0);
		send_item(CMD_UNUSED, 32'd0);
		send_item(sukset_pkg::CMD_DELETE, 32'h8000_0000);
		send_item(sukset_pkg::CMD_DUMP, '0);
	endtask

	task automatic test_random_mix(input int n);
		repeat (n)
			send_item(pick_command(), pick_key());
	endtask

	// fill to capacity, hit the full and duplicate-while-full paths, then drain to empty
	task automatic test_fill_and_drain();
		while (set_count < CAPACITY)
			send_item(sukset_pkg::CMD_INSERT, $urandom());
		repeat (3)
			send_item(sukset_pkg::CMD_INSERT, $urandom());
		send_item(sukset_pkg::CMD_INSERT, 32'h8000_0000);
		send_item(sukset_pkg::CMD_INSERT, 32'h7fff_ffff);
		send_item(sukset_pkg::CMD_INSERT, set_keys[$urandom_range(CAPACITY - 1)]);
		send_item(sukset_pkg::CMD_DUMP, $urandom());
		while (set_count > 0) begin
			if ($urandom_range(9) == 0)
				send_item(sukset_pkg::CMD_DELETE, $urandom());
			else
				send_item(sukset_pkg::CMD_DELETE, set_keys[$urandom_range(set_count - 1)]);
		end
		send_item(sukset_pkg::CMD_DUMP, $urandom());
	endtask

	// back-to-back transactions with the receiver always ready
	task automatic test_no_idle(input int n);
		gaps_on = 1'b0;
		test_random_mix(n);
		gaps_on = 1'b1;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_mix(200);
		test_fill_and_drain();
		test_no_idle(120);
		s_tvalid <= 1'b0;

		// drain every awaited result, then give a late or dropped transaction time to show
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fault_count == 0)
			$display("sorted_unique_key_set_unit verification clean");
		else
			$display("sorted_unique_key_set_unit verification failed");
		$finish;
	end

endmodule
